>>> sv/frm_pkg.sv
package frm_pkg;

	// register map
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_PREAMBLE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SYNC = 2'd1;

	// register reset values
	localparam logic [5:0] PREAMBLE_RST = 6'd27;
	localparam logic [15:0] SYNC_RST = 16'hA55A;

	// longest preamble that is sent
	localparam logic [5:0] MAX_PREAMBLE = 6'd32;

	// crc-8 constants
	localparam logic [7:0] CRC_POLY = 8'h07;
	localparam logic [7:0] CRC_TOP = 8'h80;

	// configuration as seen by the datapath
	typedef struct packed {
		logic [5:0] preamble_bytes;
		logic [15:0] sync_word;
	} cfg_t;

	// emit phase of the item in the slot
	typedef enum logic [4:0] {
		PH_PRE = 5'b00001,
		PH_SYNC_HI = 5'b00010,
		PH_SYNC_LO = 5'b00100,
		PH_DATA = 5'b01000,
		PH_CRC = 5'b10000
	} phase_t;

	// manchester code, msb first: 1 -> 01, 0 -> 10
	function automatic logic [15:0] line_code(input logic [7:0] b);
		logic [15:0] w;
		w = '0;
		for (int i = 0; i < 8; i++) begin
			w[2*i+1] = ~b[i];
			w[2*i] = b[i];
		end
		return w;
	endfunction

	// one byte through the crc-8 shift register
	function automatic logic [7:0] crc_update(input logic [7:0] crc, input logic [7:0] b);
		logic [7:0] c;
		c = crc ^ b;
		for (int j = 0; j < 8; j++) begin
			if ((c & CRC_TOP) != 8'd0) begin
				c = (c << 1) ^ CRC_POLY;
			end else begin
				c = c << 1;
			end
		end
		return c;
	endfunction

endpackage

>>> sv/frm_ifs.sv
interface frm_in_if;
	logic valid;
	logic ready;
	logic [7:0] payload_byte;
	logic last_byte;
	modport source (output valid, output payload_byte, output last_byte, input ready);
	modport sink (input valid, input payload_byte, input last_byte, output ready);
endinterface

interface frm_out_if;
	logic valid;
	logic ready;
	logic [15:0] code_word;
	logic run_end;
	logic frame_end;
	modport source (output valid, output code_word, output run_end, output frame_end,
		input ready);
	modport sink (input valid, input code_word, input run_end, input frame_end,
		output ready);
endinterface

interface frm_cfg_if;
	logic valid;
	logic ready;
	logic [frm_pkg::CFG_IDX_W-1:0] index;
	logic [15:0] data;
	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

>>> sv/frm_cfg_regs.sv
module frm_cfg_regs (
	input logic clk,
	input logic arst_n,
	frm_cfg_if.sink cfg,
	output frm_pkg::cfg_t regs
);

	logic [5:0] preamble_q;
	logic [15:0] sync_q;

	assign cfg.ready = 1'b1;

	// register writes, unknown index ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			preamble_q <= frm_pkg::PREAMBLE_RST;
			sync_q <= frm_pkg::SYNC_RST;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				frm_pkg::CFG_PREAMBLE: preamble_q <= cfg.data[5:0];
				frm_pkg::CFG_SYNC: sync_q <= cfg.data;
				default: ;
			endcase
		end
	end

	assign regs.preamble_bytes = preamble_q;
	assign regs.sync_word = sync_q;

endmodule

>>> sv/rf_frame_crc8_manchester_encoder.sv
// path: an accepted item is held in the item slot, and each word it causes is registered in the output register
// throughput: one word leaves per cycle while the output is not stalled; an item causes
//   one word within a frame, preamble + 3 for the first item of a frame (preamble capped
//   at 32), and one more for the crc word on a last item; an output stall holds the slot
// reset: arst_n clears the frame state and the crc, empties the slot and output
//   register, and returns the registers to preamble 27 and sync 0xA55A
module rf_frame_crc8_manchester_encoder (
	input logic clk,
	input logic arst_n,
	frm_in_if.sink in_ch,
	frm_out_if.source out_ch,
	frm_cfg_if.sink cfg
);

	frm_pkg::cfg_t regs;

	frm_cfg_regs u_cfg (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg),
		.regs(regs)
	);

	// frame state
	logic in_frame_q;
	logic [7:0] crc_q;

	// item slot
	logic valid_s1;
	frm_pkg::phase_t phase_s1;
	logic [5:0] cnt_s1;
	logic [7:0] byte_s1;
	logic last_s1;
	logic [7:0] crc_s1;
	logic [15:0] sync_s1;

	// output register
	logic out_valid_q;
	logic [15:0] word_q;
	logic run_end_q;
	logic frame_end_q;

	logic accept;
	logic advance;
	logic final_word;
	logic [7:0] emit_byte;
	logic [7:0] crc_next;
	logic [5:0] pre_n;
	frm_pkg::phase_t phase_next;

	assign advance = valid_s1 && (!out_valid_q || out_ch.ready);
	assign in_ch.ready = !valid_s1 || (advance && final_word);
	assign accept = in_ch.valid && in_ch.ready;

	// crc over the new byte, restarted on the first byte of a frame
	assign crc_next = frm_pkg::crc_update(in_frame_q ? crc_q : 8'd0, in_ch.payload_byte);

	// saturated preamble length
	assign pre_n = (regs.preamble_bytes > frm_pkg::MAX_PREAMBLE) ?
		frm_pkg::MAX_PREAMBLE : regs.preamble_bytes;

	// word selection and phase sequencing
	always_comb begin
		emit_byte = 8'd0;
		final_word = 1'b0;
		phase_next = phase_s1;
		unique case (phase_s1)
			frm_pkg::PH_PRE: begin
				emit_byte = 8'd0;
				phase_next = (cnt_s1 == 6'd1) ? frm_pkg::PH_SYNC_HI : frm_pkg::PH_PRE;
			end
			frm_pkg::PH_SYNC_HI: begin
				emit_byte = sync_s1[15:8];
				phase_next = frm_pkg::PH_SYNC_LO;
			end
			frm_pkg::PH_SYNC_LO: begin
				emit_byte = sync_s1[7:0];
				phase_next = frm_pkg::PH_DATA;
			end
			frm_pkg::PH_DATA: begin
				emit_byte = byte_s1;
				final_word = !last_s1;
				phase_next = frm_pkg::PH_CRC;
			end
			frm_pkg::PH_CRC: begin
				emit_byte = crc_s1;
				final_word = 1'b1;
			end
			default: ;
		endcase
	end

	// frame state, updated as each item enters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_frame_q <= 1'b0;
			crc_q <= 8'd0;
		end else if (accept) begin
			in_frame_q <= !in_ch.last_byte;
			crc_q <= in_ch.last_byte ? 8'd0 : crc_next;
		end
	end

	// slot control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			phase_s1 <= frm_pkg::PH_DATA;
			cnt_s1 <= 6'd0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
			cnt_s1 <= pre_n;
			if (in_frame_q) begin
				phase_s1 <= frm_pkg::PH_DATA;
			end else if (pre_n == 6'd0) begin
				phase_s1 <= frm_pkg::PH_SYNC_HI;
			end else begin
				phase_s1 <= frm_pkg::PH_PRE;
			end
		end else if (advance) begin
			if (final_word) begin
				valid_s1 <= 1'b0;
			end else begin
				phase_s1 <= phase_next;
				cnt_s1 <= cnt_s1 - 6'd1;
			end
		end
	end

	// slot payload
	always_ff @(posedge clk) begin
		if (accept) begin
			byte_s1 <= in_ch.payload_byte;
			last_s1 <= in_ch.last_byte;
			crc_s1 <= crc_next;
			sync_s1 <= regs.sync_word;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			word_q <= frm_pkg::line_code(emit_byte);
			run_end_q <= final_word;
			frame_end_q <= (phase_s1 == frm_pkg::PH_CRC);
		end
	end

	assign out_ch.valid = out_valid_q;
	assign out_ch.code_word = word_q;
	assign out_ch.run_end = run_end_q;
	assign out_ch.frame_end = frame_end_q;

endmodule
